[sv/kds_pkg.sv]
// Shared constants, types and helpers of the keypad debounce scanner.
package kds_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int KEY_W       = 4;
    localparam int NUM_KEYS    = 9;
    localparam int LINES_W     = 3;
    localparam int TICKS_W     = 16;
    localparam int COUNT_OUT_W = 3;

    localparam logic [LINES_W-1:0] LINES_IDLE     = 3'b111;
    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 16'd312;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [KEY_W-1:0]   head;
        t_ptr               count;
    } t_queue_status;

    function automatic t_ptr next_ptr(input t_ptr p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : t_ptr'(p + 1'b1);
    endfunction

endpackage

[sv/kds_queue.sv]
// Ring FIFO of key indexes; a push into a full ring drops the oldest entry.
module kds_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_pop,
    input  logic [kds_pkg::KEY_W-1:0] i_key,
    output kds_pkg::t_queue_status o_status
);
    import kds_pkg::*;

    logic [KEY_W-1:0] r_store [QUEUE_DEPTH];
    logic [KEY_W-1:0] r_head;
    t_ptr             r_wr_ptr;
    t_ptr             r_rd_ptr;
    t_ptr             n_wr_ptr;
    t_ptr             n_rd_ptr;
    logic             full;
    logic [PTR_W:0]   diff;
    t_ptr             count;

    assign full = (next_ptr(r_wr_ptr) == r_rd_ptr);
    assign diff = {1'b0, r_wr_ptr} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, r_rd_ptr};
    assign count = (diff >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                   t_ptr'(diff - (PTR_W+1)'(QUEUE_DEPTH)) : diff[PTR_W-1:0];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = next_ptr(r_wr_ptr);
            // full ring: advance the read side past the overwritten slot
            if (full) begin
                n_rd_ptr = next_ptr(r_rd_ptr);
            end
        end else if (i_pop && (r_wr_ptr != r_rd_ptr)) begin
            n_rd_ptr = next_ptr(r_rd_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // prefetch the next head; bypass the key written into that slot this cycle
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_key;
        end
        if (i_push && (n_rd_ptr == r_wr_ptr)) begin
            r_head <= i_key;
        end else begin
            r_head <= r_store[n_rd_ptr];
        end
    end

    always_comb begin
        o_status.empty = (r_wr_ptr == r_rd_ptr);
        o_status.full  = full;
        o_status.head  = r_head;
        o_status.count = count;
    end

endmodule

[sv/keypad_debounce_scanner_fifo.sv]
// Top level: 3x3 keypad press qualifier with debounce and key FIFO.
//
// Each input beat is a timer tick (tuser = 0, carrying the sensed column
// lines and the scanned key matrix) or a pop request (tuser = 1). Every
// input beat yields exactly one output beat. The block takes one beat per
// clock while the output side is not stalled; a beat passes an input
// register and then a result register, whose beat leaves when the output
// side is ready. A stalled output holds both registers and stops the input
// after two beats. The phase machine, debounce counter and ring pointer
// update sit in one stage between those registers. The FIFO holds
// QUEUE_DEPTH-1 keys and drops the oldest on overflow. Write
// debounce_ticks only while idle; zero behaves as one.
module keypad_debounce_scanner_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] column_lines, [11:3] key_matrix, [15:12] zero
    input  logic [15:0] s_axis_tdata,
    // [0] kind
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] key_valid, [9:1] key_onehot, [10] key_queued, [11] dropped_oldest,
    // [14:12] queue_count, [16:15] scan_phase, [23:17] zero
    output logic [23:0] m_axis_tdata
);
    import kds_pkg::*;

    typedef enum logic [2:0] {
        PH_RELEASE  = 3'b001,
        PH_PRESS    = 3'b010,
        PH_DEBOUNCE = 3'b100
    } t_phase;

    // input register
    logic                r_a_valid;
    logic                r_a_kind;
    logic [LINES_W-1:0]  r_a_lines;
    logic [NUM_KEYS-1:0] r_a_keys;

    // result register
    logic                r_b_valid;
    logic [M_TDATA_W-1:0] r_b_data;

    logic [TICKS_W-1:0]  r_ticks;
    t_phase              r_phase;
    t_phase              n_phase;
    logic [TICKS_W-1:0]  r_left;
    logic [TICKS_W-1:0]  n_left;

    logic                adv;
    logic                push;
    logic                pop;
    logic                one_key;
    logic [KEY_W-1:0]    key_idx;
    t_queue_status       q_stat;

    logic                res_valid;
    logic [NUM_KEYS-1:0] res_onehot;
    logic                res_dropped;
    t_ptr                cnt_after;
    logic [PTR_W+COUNT_OUT_W-1:0] cnt_ext;
    logic [1:0]          phase_code;
    logic [M_TDATA_W-1:0] n_b_data;

    assign adv           = r_a_valid && (!r_b_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || adv;
    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tdata  = r_b_data;

    assign one_key = (r_a_keys != '0) && ((r_a_keys & (r_a_keys - 1'b1)) == '0);

    always_comb begin
        key_idx = '0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (r_a_keys[i]) begin
                key_idx = KEY_W'(i);
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        push       = 1'b0;
        pop        = 1'b0;
        res_valid  = 1'b0;
        res_onehot = '0;
        if (r_a_kind) begin
            pop        = !q_stat.empty;
            res_valid  = !q_stat.empty;
            res_onehot = q_stat.empty ? '0 : (NUM_KEYS'(1) << q_stat.head);
        end else begin
            case (r_phase)
                PH_PRESS: begin
                    if (r_a_lines != LINES_IDLE) begin
                        n_phase = PH_DEBOUNCE;
                        n_left  = r_ticks;
                    end
                end
                PH_DEBOUNCE: begin
                    if (r_left <= TICKS_W'(1)) begin
                        n_left  = '0;
                        push    = one_key;
                        n_phase = (r_a_lines == LINES_IDLE) ? PH_PRESS : PH_RELEASE;
                    end else begin
                        n_left = r_left - 1'b1;
                    end
                end
                default: begin
                    n_phase = (r_a_lines == LINES_IDLE) ? PH_PRESS : PH_RELEASE;
                end
            endcase
        end
    end

    assign res_dropped = push && q_stat.full;

    always_comb begin
        cnt_after = q_stat.count;
        if (push && !q_stat.full) begin
            cnt_after = t_ptr'(q_stat.count + 1'b1);
        end else if (pop) begin
            cnt_after = t_ptr'(q_stat.count - 1'b1);
        end
    end

    assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_after};

    always_comb begin
        case (n_phase)
            PH_PRESS:    phase_code = 2'd1;
            PH_DEBOUNCE: phase_code = 2'd2;
            default:     phase_code = 2'd0;
        endcase
    end

    assign n_b_data = {7'd0, phase_code, cnt_ext[COUNT_OUT_W-1:0], res_dropped, push,
                       res_onehot, res_valid};

    kds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv && push),
        .i_pop   (adv && pop),
        .i_key   (key_idx),
        .o_status(q_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks   <= DEBOUNCE_RESET;
            r_phase   <= PH_RELEASE;
            r_left    <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ticks <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_a_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_phase   <= n_phase;
                r_left    <= n_left;
                r_b_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_a_kind  <= s_axis_tuser[0];
            r_a_lines <= s_axis_tdata[LINES_W-1:0];
            r_a_keys  <= s_axis_tdata[LINES_W+NUM_KEYS-1:LINES_W];
        end
        if (adv) begin
            r_b_data <= n_b_data;
        end
    end

endmodule

[sv/kds_checker.sv]
// Port-level checker for the keypad scanner, bound to the top level.
module kds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat right after reset");

    a_pop_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> $onehot(m_axis_tdata[9:1]))
        else $error("popped key is not one-hot");

    a_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[9:1] == 9'd0))
        else $error("key mask set without a valid key");

    a_drop_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11] |->
            (m_axis_tdata[10] && !m_axis_tdata[0] && (m_axis_tdata[16:15] != 2'd3)))
        else $error("drop without a queued key");

endmodule

bind keypad_debounce_scanner_fifo kds_checker u_kds_checker (.*);
